>>> rtl/core/s2d_pkg.sv
package s2d_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int BCD_W          = 4;
  localparam int CHAR_W         = 8;
  localparam int COUNT_W        = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  // per-cycle command shared by every digit cell
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 adjust, then shift one binary bit in
    logic move;    // take the lower neighbor's whole digit
  } cell_ctrl_t;

endpackage

>>> rtl/core/s2d_bcd_cell.sv
module s2d_bcd_cell (
  input  logic                          clk,
  input  s2d_pkg::cell_ctrl_t           ctrl,
  input  logic                          bit_in,
  input  logic [s2d_pkg::BCD_W-1:0]     digit_in,
  output logic                          bit_out,
  output logic [s2d_pkg::BCD_W-1:0]     digit
);
  import s2d_pkg::*;

  logic [BCD_W-1:0] adj;

  // add 3 when the digit would reach ten after doubling
  assign adj     = (digit >= BCD_W'(5)) ? digit + BCD_W'(3) : digit;
  assign bit_out = adj[BCD_W-1];

  always_ff @(posedge clk) begin
    priority if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[BCD_W-2:0], bit_in};
    end else if (ctrl.move) begin
      digit <= digit_in;
    end else begin
      digit <= digit;
    end
  end

endmodule

>>> rtl/core/s2d_digit_chain.sv
module s2d_digit_chain #(
  parameter int Digits = 10
) (
  input  logic                          clk,
  input  s2d_pkg::cell_ctrl_t           ctrl,
  input  logic                          bit_in,
  output logic [s2d_pkg::BCD_W-1:0]     top_digit
);
  import s2d_pkg::*;

  logic [BCD_W-1:0] dig   [Digits];
  logic             carry [Digits];

  for (genvar i = 0; i < Digits; i++) begin : g_cell
    logic             cin;
    logic [BCD_W-1:0] din;

    // lowest cell takes the magnitude bit and a zero digit
    if (i == 0) begin : g_low
      assign cin = bit_in;
      assign din = '0;
    end else begin : g_up
      assign cin = carry[i-1];
      assign din = dig[i-1];
    end

    s2d_bcd_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (cin),
      .digit_in (din),
      .bit_out  (carry[i]),
      .digit    (dig[i])
    );
  end

  assign top_digit = dig[Digits-1];

endmodule

>>> rtl/core/signed_binary_to_decimal_ascii_core.sv
// after an accept the magnitude is shifted into the digit chain (CONVERT) and leading zero
// digits are dropped (SKIP); then one item per cycle while the output is not stalled:
// optional '-', the digits, and a nul item marked last; the next value is taken once the
// nul item is in the output register
// reset (rst, synchronous) empties the output register and returns the sequencer to idle
module signed_binary_to_decimal_ascii_core #(
  parameter int VALUE_BITS = s2d_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value (signed)
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] character, [11:8] byte_count, [15:12] zero
  output logic        m_tlast
);
  import s2d_pkg::*;

  // enough bcd cells for the largest magnitude, 2**(VALUE_BITS-1)
  localparam int Digits = (VALUE_BITS * 3) / 10 + 1;
  localparam int BitCntW = $clog2(VALUE_BITS + 1);
  localparam int RemW    = $clog2(Digits + 1);

  typedef enum logic [2:0] {
    IDLE,
    CONVERT,  // double dabble, one magnitude bit per cycle
    SKIP,     // drop leading zero digits off the top of the chain
    SIGN,
    DIGITS,
    TERM
  } state_t;

  state_t               state;
  logic                 negative;
  logic [VALUE_BITS-1:0] mag;
  logic [BitCntW-1:0]   bit_cnt;
  logic [RemW-1:0]      rem;      // digits still in the chain
  logic [COUNT_W-1:0]   nbytes;   // items sent so far for this value

  logic signed [63:0]    ext;
  logic [VALUE_BITS-1:0] raw;
  logic                  in_neg;
  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic                  skip_more;
  logic [BCD_W-1:0]      top_digit;
  cell_ctrl_t            ctrl;

  // only the low VALUE_BITS of the sign-extended value count
  assign ext    = 64'(signed'(s_tdata));
  assign raw    = ext[VALUE_BITS-1:0];
  assign in_neg = raw[VALUE_BITS-1];

  assign s_tready  = (state == IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign skip_more = (top_digit == '0) && (rem > RemW'(1));
  assign out_load  = out_free && ((state == SIGN) || (state == DIGITS) || (state == TERM));

  always_comb begin
    ctrl.clear  = in_acc;
    ctrl.dabble = (state == CONVERT);
    ctrl.move   = ((state == SKIP) && skip_more) || ((state == DIGITS) && out_free);
  end

  s2d_digit_chain #(
    .Digits (Digits)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (mag[VALUE_BITS-1]),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      // output register fills from the sequencer, drains when taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_acc) begin
            negative <= in_neg;
            // unsigned negate, so the most negative value keeps its digits
            mag      <= in_neg ? (~raw + VALUE_BITS'(1)) : raw;
            bit_cnt  <= BitCntW'(VALUE_BITS);
            nbytes   <= '0;
            state    <= CONVERT;
          end
        end
        CONVERT: begin
          mag     <= mag << 1;
          bit_cnt <= bit_cnt - BitCntW'(1);
          if (bit_cnt == BitCntW'(1)) begin
            rem   <= RemW'(Digits);
            state <= SKIP;
          end
        end
        SKIP: begin
          if (skip_more) begin
            rem <= rem - RemW'(1);
          end else begin
            state <= negative ? SIGN : DIGITS;
          end
        end
        SIGN: begin
          if (out_free) begin
            m_tlast  <= 1'b0;
            m_tdata  <= {4'h0, {COUNT_W{1'b0}}, CHAR_MINUS};
            nbytes   <= nbytes + COUNT_W'(1);
            state    <= DIGITS;
          end
        end
        DIGITS: begin
          if (out_free) begin
            m_tlast  <= 1'b0;
            m_tdata  <= {4'h0, {COUNT_W{1'b0}}, CHAR_ZERO + CHAR_W'(top_digit)};
            nbytes   <= nbytes + COUNT_W'(1);
            rem      <= rem - RemW'(1);
            if (rem == RemW'(1)) begin
              state <= TERM;
            end
          end
        end
        TERM: begin
          if (out_free) begin
            m_tlast  <= 1'b1;
            m_tdata  <= {4'h0, nbytes + COUNT_W'(1), CHAR_NUL};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // nothing is emitted while the conversion is still shifting
  a_no_out_in_convert: assert property (@(posedge clk) disable iff (rst)
    (state == CONVERT) |-> !out_load)
    else $error("output loaded during conversion");

  // a digit leaving the chain is a valid bcd digit
  a_digit_bcd: assert property (@(posedge clk) disable iff (rst)
    ((state == DIGITS) && out_free) |-> (top_digit <= BCD_W'(9)))
    else $error("non-decimal digit emitted");

  // the chain never runs dry while digits are pending
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((state == SKIP) || (state == DIGITS)) |-> (rem != '0))
    else $error("digit count underflow");

  // the terminator is a nul with at least one char before it
  a_term_item: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> ((m_tdata[7:0] == CHAR_NUL) && (m_tdata[11:8] != 4'd1)))
    else $error("bad terminator item");

  // an accepted value always starts a conversion
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == CONVERT))
    else $error("accept did not start a conversion");

endmodule
